@@ rtl/core/obb_pkg.sv @@
// Shared constants for the 2D oriented box overlap pipeline.
`timescale 1ns / 1ps

package obb_pkg;

   // integer bits of an axis component; the rest are fraction bits
   localparam int AXIS_INT_BITS = 2;

   // width of the result word on the response channel
   localparam int RSP_DATA_W = 8;

endpackage

@@ rtl/core/obb_overlap_test_2d.sv @@
// Top level of the 2D oriented box separating-axis overlap pipeline.
//
//   channel  dir  word                                  handshake
//   req_     in   two boxes, box A then box B           req_tvalid / req_tready
//   rsp_     out  overlap flag, one per request word    rsp_tvalid / rsp_tready
//
// One word per cycle while the response side does not stall; four register stages,
// so a result is registered in turn in the offset, projection, radius and result
// stages before it is offered on the response channel.
// The stage multipliers (axis products, offset products, radius products) set
// the stage depth. Reset clears the stage valid bits only. Each stage holds
// its word while the next one is blocked, and an empty stage fills in behind it.
`timescale 1ns / 1ps

module obb_overlap_test_2d #(
   parameter int COORD_WIDTH = 32,
   parameter int AXIS_WIDTH = 16,
   localparam int BOX_BITS = 4 * COORD_WIDTH + 2 * AXIS_WIDTH - 2,
   localparam int REQ_BITS = 2 * BOX_BITS,
   localparam int REQ_W = ((REQ_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // a_center_x, a_center_y, a_axis_x, a_axis_y, a_half_w, a_half_h,
   // b_center_x, b_center_y, b_axis_x, b_axis_y, b_half_w, b_half_h, zero pad
   input  logic [REQ_W-1:0]                req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // overlap, zero pad
   output logic [obb_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   import obb_pkg::*;

   localparam int EW = COORD_WIDTH - 1;
   localparam int PRW = 2 * AXIS_WIDTH;
   localparam int OPW = COORD_WIDTH + AXIS_WIDTH + 2;
   localparam int TW = COORD_WIDTH + 2 * AXIS_WIDTH - 1;
   localparam int RPW = EW + PRW;

   logic                  p_valid, p_ready;
   logic [PRW-1:0]        p_pr [4];
   logic signed [OPW-1:0] p_op [8];
   logic [EW-1:0]         p_ext [4];

   logic                  r_valid, r_ready;
   logic [TW-1:0]         r_t [4];
   logic [RPW-1:0]        r_rp [8];
   logic [EW-1:0]         r_ext [4];

   logic                  overlap;

   obb_proj #(
      .COORD_WIDTH (COORD_WIDTH),
      .AXIS_WIDTH  (AXIS_WIDTH)
   ) u_proj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata[REQ_BITS-1:0]),
      .out_valid (p_valid),
      .out_ready (p_ready),
      .out_pr    (p_pr),
      .out_op    (p_op),
      .out_ext   (p_ext)
   );

   obb_radius #(
      .COORD_WIDTH (COORD_WIDTH),
      .AXIS_WIDTH  (AXIS_WIDTH)
   ) u_radius (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_ready  (p_ready),
      .in_pr     (p_pr),
      .in_op     (p_op),
      .in_ext    (p_ext),
      .out_valid (r_valid),
      .out_ready (r_ready),
      .out_t     (r_t),
      .out_rp    (r_rp),
      .out_ext   (r_ext)
   );

   obb_cmp #(
      .COORD_WIDTH (COORD_WIDTH),
      .AXIS_WIDTH  (AXIS_WIDTH)
   ) u_cmp (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (r_valid),
      .in_ready    (r_ready),
      .in_t        (r_t),
      .in_rp       (r_rp),
      .in_ext      (r_ext),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_overlap (overlap)
   );

   assign rsp_tdata = {{(RSP_DATA_W - 1){1'b0}}, overlap};

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && !p_valid && !r_valid)
      else $error("pipeline holds a word right after reset");
`endif

endmodule

@@ rtl/core/obb_proj.sv @@
// Front stages: center offset, axis dot products, offset projection products.
`timescale 1ns / 1ps

module obb_proj #(
   parameter int COORD_WIDTH = 32,
   parameter int AXIS_WIDTH = 16,
   localparam int BOX_BITS = 4 * COORD_WIDTH + 2 * AXIS_WIDTH - 2,
   localparam int IN_BITS = 2 * BOX_BITS,
   localparam int EW = COORD_WIDTH - 1,
   localparam int PRW = 2 * AXIS_WIDTH,
   localparam int OPW = COORD_WIDTH + AXIS_WIDTH + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [IN_BITS-1:0]    in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [PRW-1:0]        out_pr [4],
   output logic signed [OPW-1:0] out_op [8],
   output logic [EW-1:0]         out_ext [4]
);

   import obb_pkg::*;

   localparam int C = COORD_WIDTH;
   localparam int A = AXIS_WIDTH;
   localparam int VW = C + 1;
   localparam int AE = A + 1;
   localparam int PPW = 2 * AE;
   localparam int DW = PPW + 1;
   localparam int O_ACY = C;
   localparam int O_AAX = 2 * C;
   localparam int O_AAY = 2 * C + A;
   localparam int O_AW = 2 * C + 2 * A;
   localparam int O_AH = 3 * C + 2 * A - 1;

   logic signed [C-1:0] acx, acy, bcx, bcy;
   logic signed [A-1:0] aax, aay, bax, bay;
   logic signed [AE-1:0] aax_e, aay_e, bax_e, bay_e;

   logic                  s1_v_ff, s1_v_in, s1_rdy;
   logic signed [VW-1:0]  s1_vx_ff, s1_vx_in, s1_vy_ff, s1_vy_in;
   logic signed [AE-1:0]  s1_ux_ff [4], s1_ux_in [4];
   logic signed [AE-1:0]  s1_uy_ff [4], s1_uy_in [4];
   logic signed [PPW-1:0] s1_pp_ff [8], s1_pp_in [8];
   logic [EW-1:0]         s1_ext_ff [4], s1_ext_in [4];

   logic                  s2_v_ff, s2_v_in, s2_rdy;
   logic [PRW-1:0]        s2_pr_ff [4], s2_pr_in [4];
   logic signed [OPW-1:0] s2_op_ff [8], s2_op_in [8];
   logic [EW-1:0]         s2_ext_ff [4];

   logic signed [DW-1:0]  dot [4];
   logic [DW-1:0]         dot_mag [4];

   assign acx = in_data[0 +: C];
   assign acy = in_data[O_ACY +: C];
   assign aax = in_data[O_AAX +: A];
   assign aay = in_data[O_AAY +: A];
   assign bcx = in_data[BOX_BITS +: C];
   assign bcy = in_data[BOX_BITS + O_ACY +: C];
   assign bax = in_data[BOX_BITS + O_AAX +: A];
   assign bay = in_data[BOX_BITS + O_AAY +: A];

   assign aax_e = {aax[A-1], aax};
   assign aay_e = {aay[A-1], aay};
   assign bax_e = {bax[A-1], bax};
   assign bay_e = {bay[A-1], bay};

   assign s2_rdy = !s2_v_ff || out_ready;
   assign s1_rdy = !s1_v_ff || s2_rdy;
   assign in_ready = s1_rdy;

   always_comb begin
      s1_v_in = in_valid;
      s1_vx_in = {bcx[C-1], bcx} - {acx[C-1], acx};
      s1_vy_in = {bcy[C-1], bcy} - {acy[C-1], acy};
      s1_ux_in[0] = aax_e;
      s1_uy_in[0] = aay_e;
      s1_ux_in[1] = -aay_e;
      s1_uy_in[1] = aax_e;
      s1_ux_in[2] = bax_e;
      s1_uy_in[2] = bay_e;
      s1_ux_in[3] = -bay_e;
      s1_uy_in[3] = bax_e;
      s1_ext_in[0] = in_data[O_AW +: EW];
      s1_ext_in[1] = in_data[O_AH +: EW];
      s1_ext_in[2] = in_data[BOX_BITS + O_AW +: EW];
      s1_ext_in[3] = in_data[BOX_BITS + O_AH +: EW];
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            s1_pp_in[4 * i + 2 * j]     = PPW'(s1_ux_in[i]) * PPW'(s1_ux_in[2 + j]);
            s1_pp_in[4 * i + 2 * j + 1] = PPW'(s1_uy_in[i]) * PPW'(s1_uy_in[2 + j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_v_ff <= s1_v_in;
      end
      if (s1_rdy && in_valid) begin
         s1_vx_ff <= s1_vx_in;
         s1_vy_ff <= s1_vy_in;
         s1_ux_ff <= s1_ux_in;
         s1_uy_ff <= s1_uy_in;
         s1_pp_ff <= s1_pp_in;
         s1_ext_ff <= s1_ext_in;
      end
   end

   always_comb begin
      s2_v_in = s1_v_ff;
      for (int m = 0; m < 4; m++) begin
         dot[m] = DW'(s1_pp_ff[2 * m]) + DW'(s1_pp_ff[2 * m + 1]);
         dot_mag[m] = dot[m][DW-1] ? DW'(-dot[m]) : DW'(dot[m]);
         s2_pr_in[m] = dot_mag[m][PRW-1:0];
         s2_op_in[2 * m]     = OPW'(s1_vx_ff) * OPW'(s1_ux_ff[m]);
         s2_op_in[2 * m + 1] = OPW'(s1_vy_ff) * OPW'(s1_uy_ff[m]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_v_ff <= s2_v_in;
      end
      if (s2_rdy && s1_v_ff) begin
         s2_pr_ff <= s2_pr_in;
         s2_op_ff <= s2_op_in;
         s2_ext_ff <= s1_ext_ff;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_pr = s2_pr_ff;
   assign out_op = s2_op_ff;
   assign out_ext = s2_ext_ff;

`ifndef SYNTHESIS
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s2_rdy |=> s1_v_ff && $stable(s1_vx_ff) && $stable(s1_pp_ff[0]))
      else $error("first stage word changed while blocked");
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !out_ready |=> s2_v_ff && $stable(s2_op_ff[0]) && $stable(s2_pr_ff[0]))
      else $error("second stage word changed while blocked");
`endif

endmodule

@@ rtl/core/obb_radius.sv @@
// Middle stage: projected center offsets and radius products on all four axes.
`timescale 1ns / 1ps

module obb_radius #(
   parameter int COORD_WIDTH = 32,
   parameter int AXIS_WIDTH = 16,
   localparam int EW = COORD_WIDTH - 1,
   localparam int PRW = 2 * AXIS_WIDTH,
   localparam int OPW = COORD_WIDTH + AXIS_WIDTH + 2,
   localparam int TW = COORD_WIDTH + 2 * AXIS_WIDTH - 1,
   localparam int RPW = EW + PRW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [PRW-1:0]        in_pr [4],
   input  logic signed [OPW-1:0] in_op [8],
   input  logic [EW-1:0]         in_ext [4],
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [TW-1:0]         out_t [4],
   output logic [RPW-1:0]        out_rp [8],
   output logic [EW-1:0]         out_ext [4]
);

   import obb_pkg::*;

   localparam int F = AXIS_WIDTH - AXIS_INT_BITS;
   localparam int OSW = OPW + 1;
   localparam int MW = COORD_WIDTH + AXIS_WIDTH + 1;

   logic                  s3_v_ff, s3_v_in, s3_rdy;
   logic [TW-1:0]         s3_t_ff [4], s3_t_in [4];
   logic [RPW-1:0]        s3_rp_ff [8], s3_rp_in [8];
   logic [EW-1:0]         s3_ext_ff [4];

   logic signed [OSW-1:0] osum [4];
   logic [OSW-1:0]        omag [4];

   assign s3_rdy = !s3_v_ff || out_ready;
   assign in_ready = s3_rdy;

   always_comb begin
      s3_v_in = in_valid;
      for (int k = 0; k < 4; k++) begin
         osum[k] = OSW'(in_op[2 * k]) + OSW'(in_op[2 * k + 1]);
         omag[k] = osum[k][OSW-1] ? OSW'(-osum[k]) : OSW'(osum[k]);
         s3_t_in[k] = {omag[k][MW-1:0], {F{1'b0}}};
      end
      for (int k = 0; k < 2; k++) begin
         s3_rp_in[2 * k]         = RPW'(in_ext[2]) * RPW'(in_pr[2 * k]);
         s3_rp_in[2 * k + 1]     = RPW'(in_ext[3]) * RPW'(in_pr[2 * k + 1]);
         s3_rp_in[4 + 2 * k]     = RPW'(in_ext[0]) * RPW'(in_pr[k]);
         s3_rp_in[4 + 2 * k + 1] = RPW'(in_ext[1]) * RPW'(in_pr[2 + k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (s3_rdy) begin
         s3_v_ff <= s3_v_in;
      end
      if (s3_rdy && in_valid) begin
         s3_t_ff <= s3_t_in;
         s3_rp_ff <= s3_rp_in;
         s3_ext_ff <= in_ext;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_t = s3_t_ff;
   assign out_rp = s3_rp_ff;
   assign out_ext = s3_ext_ff;

`ifndef SYNTHESIS
   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      s3_v_ff && !out_ready |=> s3_v_ff && $stable(s3_t_ff[0]) && $stable(s3_rp_ff[0]))
      else $error("third stage word changed while blocked");
`endif

endmodule

@@ rtl/core/obb_cmp.sv @@
// Final stage: radius sums, separation compares and the result register.
`timescale 1ns / 1ps

module obb_cmp #(
   parameter int COORD_WIDTH = 32,
   parameter int AXIS_WIDTH = 16,
   localparam int EW = COORD_WIDTH - 1,
   localparam int PRW = 2 * AXIS_WIDTH,
   localparam int TW = COORD_WIDTH + 2 * AXIS_WIDTH - 1,
   localparam int RPW = EW + PRW
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [TW-1:0]  in_t [4],
   input  logic [RPW-1:0] in_rp [8],
   input  logic [EW-1:0]  in_ext [4],
   output logic           out_valid,
   input  logic           out_ready,
   output logic           out_overlap
);

   import obb_pkg::*;

   localparam int F = AXIS_WIDTH - AXIS_INT_BITS;
   localparam int SUMW = RPW + 2;

   logic            s4_v_ff, s4_rdy;
   logic            s4_ovl_ff, s4_ovl_in;
   logic [SUMW-1:0] rsum [4];
   logic [3:0]      sep;

   assign s4_rdy = !s4_v_ff || out_ready;
   assign in_ready = s4_rdy;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rsum[k] = SUMW'({in_ext[k], {(2 * F){1'b0}}}) + SUMW'(in_rp[2 * k])
                 + SUMW'(in_rp[2 * k + 1]);
         sep[k] = SUMW'(in_t[k]) > rsum[k];
      end
      s4_ovl_in = ~|sep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (s4_rdy) begin
         s4_v_ff <= in_valid;
      end
      if (s4_rdy && in_valid) begin
         s4_ovl_ff <= s4_ovl_in;
      end
   end

   assign out_valid = s4_v_ff;
   assign out_overlap = s4_ovl_ff;

endmodule
